// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and search functions for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int PAGE_W     = 6;    // 64 pages
    localparam int OFF_W      = 12;   // 4 KB page
    localparam int ADDR_W     = PAGE_W + OFF_W;
    localparam int CLS_W      = 3;    // 8 size classes
    localparam int ROW_W      = 256;  // class 0 slots in one page
    localparam int ROW_IDX_W  = 8;
    localparam int RAM_ADDR_W = CLS_W + PAGE_W;
    localparam int PAGES      = 1 << PAGE_W;
    localparam int CLASSES    = 1 << CLS_W;
    localparam int COUNT_W    = 7;
    localparam int REQ_W      = 12;
    localparam logic [ADDR_W-1:0] HEADER_BYTES = ADDR_W'(16);
    localparam logic [CLS_W:0]    TOP_CLASS    = (CLS_W + 1)'(CLASSES - 1);

    typedef enum logic [2:0] {
        ST_ALLOC = 3'd0,
        ST_FREED = 3'd1,
        ST_ZERO  = 3'd2,
        ST_LARGE = 3'd3,
        ST_OOM   = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_SEARCH,
        S_TAKE,
        S_SPLIT_RD,
        S_SPLIT_WR,
        S_FREE_RD,
        S_FREE_WR,
        S_FINISH
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   addr;
        logic [CLS_W-1:0]    cls;
        logic [COUNT_W-1:0]  pages;
    } res_t;

    // lowest set bit of a 64-bit word
    function automatic logic [PAGE_W-1:0] ffs64(input logic [PAGES-1:0] v);
        logic [PAGE_W-1:0] idx;
        idx = '0;
        for (int i = PAGES - 1; i >= 0; i--) begin
            if (v[i]) idx = PAGE_W'(i);
        end
        return idx;
    endfunction

    // lowest set bit of a row
    function automatic logic [ROW_IDX_W-1:0] ffs_row(input logic [ROW_W-1:0] v);
        logic [ROW_IDX_W-1:0] idx;
        idx = '0;
        for (int i = ROW_W - 1; i >= 0; i--) begin
            if (v[i]) idx = ROW_IDX_W'(i);
        end
        return idx;
    endfunction

endpackage

// ===== hw/rtl/bba_row_ram.sv =====
// ----------------------------------------------------------------------------
// bba_row_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bba_row_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 256
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/bba_engine.sv =====
// ----------------------------------------------------------------------------
// bba_engine
// Request sequencer: class search, block take, split and merge over the
// per-(class, page) free rows, with row summaries and page bookkeeping.
// ----------------------------------------------------------------------------
module bba_engine (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic                                 req_func,
    input  logic [bba_pkg::REQ_W-1:0]            req_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]           req_addr,
    input  logic [bba_pkg::CLS_W-1:0]            req_cls,
    output logic                                 ram_we,
    output logic [bba_pkg::RAM_ADDR_W-1:0]       ram_waddr,
    output logic [bba_pkg::ROW_W-1:0]            ram_wdata,
    output logic [bba_pkg::RAM_ADDR_W-1:0]       ram_raddr,
    input  logic [bba_pkg::ROW_W-1:0]            ram_rdata,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output bba_pkg::res_t                        res
);

    bba_pkg::state_t                       state_reg, state_next;
    logic                                  func_reg, func_next;
    logic [bba_pkg::REQ_W-1:0]             bytes_reg, bytes_next;
    logic [bba_pkg::ADDR_W-1:0]            faddr_reg, faddr_next;
    logic [bba_pkg::CLS_W-1:0]             fcls_reg, fcls_next;
    logic [bba_pkg::CLS_W:0]               c_reg, c_next;
    logic [bba_pkg::CLS_W-1:0]             creq_reg, creq_next;
    logic [bba_pkg::PAGE_W-1:0]            page_reg, page_next;
    logic [bba_pkg::OFF_W-1:0]             off_reg, off_next;
    logic                                  first_reg, first_next;
    bba_pkg::status_t                      status_reg, status_next;
    logic [bba_pkg::ADDR_W-1:0]            raddr_reg, raddr_next;
    logic [bba_pkg::CLS_W-1:0]             rcls_reg, rcls_next;
    logic [bba_pkg::CLASSES-1:0][bba_pkg::PAGES-1:0] sum_reg, sum_next;
    logic [bba_pkg::PAGES-1:0]             taken_reg, taken_next;
    logic [bba_pkg::COUNT_W-1:0]           count_reg, count_next;

    logic [bba_pkg::CLS_W-1:0]             c3;
    logic [bba_pkg::ROW_W-1:0]             row;
    logic [bba_pkg::ROW_W-1:0]             row_new;
    logic [bba_pkg::ROW_IDX_W-1:0]         bidx;
    logic [bba_pkg::ROW_IDX_W-1:0]         buddy;
    logic [bba_pkg::ROW_IDX_W-1:0]         hit;
    logic [bba_pkg::ADDR_W:0]              need;
    logic [bba_pkg::ADDR_W-1:0]            fb;
    logic [bba_pkg::CLS_W-1:0]             cfit;
    logic                                  cfit_ok;
    logic [bba_pkg::PAGE_W-1:0]            sp;
    logic [bba_pkg::PAGE_W-1:0]            fp;
    logic [bba_pkg::ADDR_W-1:0]            start;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= bba_pkg::S_IDLE;
            sum_reg   <= '0;
            taken_reg <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            taken_reg <= taken_next;
            count_reg <= count_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        func_reg   <= func_next;
        bytes_reg  <= bytes_next;
        faddr_reg  <= faddr_next;
        fcls_reg   <= fcls_next;
        c_reg      <= c_next;
        creq_reg   <= creq_next;
        page_reg   <= page_next;
        off_reg    <= off_next;
        first_reg  <= first_next;
        status_reg <= status_next;
        raddr_reg  <= raddr_next;
        rcls_reg   <= rcls_next;
    end

    // next state and datapath
    always_comb begin
        state_next  = state_reg;
        func_next   = func_reg;
        bytes_next  = bytes_reg;
        faddr_next  = faddr_reg;
        fcls_next   = fcls_reg;
        c_next      = c_reg;
        creq_next   = creq_reg;
        page_next   = page_reg;
        off_next    = off_reg;
        first_next  = first_reg;
        status_next = status_reg;
        raddr_next  = raddr_reg;
        rcls_next   = rcls_reg;
        sum_next    = sum_reg;
        taken_next  = taken_reg;
        count_next  = count_reg;

        req_ready = 1'b0;
        res_valid = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = {c_reg[bba_pkg::CLS_W-1:0], page_reg};
        ram_wdata = '0;
        ram_raddr = {c_reg[bba_pkg::CLS_W-1:0], page_reg};

        c3 = c_reg[bba_pkg::CLS_W-1:0];
        // rows whose summary bit is clear read as empty
        row = sum_reg[c3][page_reg] ? ram_rdata : '0;
        row_new = row;
        bidx  = bba_pkg::ROW_IDX_W'(off_reg >> (4 + c3));
        buddy = bidx ^ bba_pkg::ROW_IDX_W'(1);
        hit   = bba_pkg::ffs_row(row);
        sp    = bba_pkg::ffs64(sum_reg[c3]);
        fp    = bba_pkg::ffs64(~taken_reg);
        start = {page_reg, off_reg};

        // smallest class that holds payload plus header
        need = {7'd0, bytes_reg} + (bba_pkg::ADDR_W + 1)'(16);
        cfit = '0;
        cfit_ok = 1'b0;
        for (int k = bba_pkg::CLASSES - 1; k >= 0; k--) begin
            if (((bba_pkg::ADDR_W + 1)'(16) << k) >= need) begin
                cfit = bba_pkg::CLS_W'(k);
                cfit_ok = 1'b1;
            end
        end

        // block start of a free, aligned down to its class size
        fb = faddr_reg - bba_pkg::HEADER_BYTES;
        fb = fb & ~((bba_pkg::ADDR_W'(16) << fcls_reg) - bba_pkg::ADDR_W'(1));

        unique case (state_reg)
            bba_pkg::S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    func_next  = req_func;
                    bytes_next = req_bytes;
                    faddr_next = req_addr;
                    fcls_next  = req_cls;
                    state_next = bba_pkg::S_START;
                end
            end
            bba_pkg::S_START: begin
                raddr_next = '0;
                rcls_next  = '0;
                if (!func_reg) begin
                    priority if (bytes_reg == '0) begin
                        status_next = bba_pkg::ST_ZERO;
                        state_next  = bba_pkg::S_FINISH;
                    end else if (!cfit_ok) begin
                        status_next = bba_pkg::ST_LARGE;
                        state_next  = bba_pkg::S_FINISH;
                    end else begin
                        creq_next  = cfit;
                        c_next     = {1'b0, cfit};
                        state_next = bba_pkg::S_SEARCH;
                    end
                end else begin
                    status_next = bba_pkg::ST_FREED;
                    page_next   = fb[bba_pkg::ADDR_W-1:bba_pkg::OFF_W];
                    off_next    = fb[bba_pkg::OFF_W-1:0];
                    c_next      = {1'b0, fcls_reg};
                    first_next  = 1'b1;
                    if (faddr_reg < bba_pkg::HEADER_BYTES ||
                        !taken_reg[fb[bba_pkg::ADDR_W-1:bba_pkg::OFF_W]]) begin
                        state_next = bba_pkg::S_FINISH;
                    end else begin
                        state_next = bba_pkg::S_FREE_RD;
                    end
                end
            end
            bba_pkg::S_SEARCH: begin
                // one class per cycle, lowest page with a free block
                if (|sum_reg[c3]) begin
                    ram_raddr  = {c3, sp};
                    page_next  = sp;
                    state_next = bba_pkg::S_TAKE;
                end else if (c_reg == bba_pkg::TOP_CLASS) begin
                    if (&taken_reg) begin
                        status_next = bba_pkg::ST_OOM;
                        state_next  = bba_pkg::S_FINISH;
                    end else begin
                        taken_next[fp] = 1'b1;
                        count_next = count_reg + bba_pkg::COUNT_W'(1);
                        page_next  = fp;
                        off_next   = '0;
                        c_next     = bba_pkg::TOP_CLASS + (bba_pkg::CLS_W + 1)'(1);
                        status_next = bba_pkg::ST_ALLOC;
                        raddr_next = {fp, bba_pkg::OFF_W'(0)} + bba_pkg::HEADER_BYTES;
                        rcls_next  = creq_reg;
                        state_next = bba_pkg::S_SPLIT_RD;
                    end
                end else begin
                    c_next = c_reg + (bba_pkg::CLS_W + 1)'(1);
                end
            end
            bba_pkg::S_TAKE: begin
                // clear the lowest free slot of the row
                row_new = row;
                row_new[hit] = 1'b0;
                ram_we    = 1'b1;
                ram_wdata = row_new;
                sum_next[c3][page_reg] = |row_new;
                off_next = bba_pkg::OFF_W'({4'd0, hit} << (4 + c3));
                status_next = bba_pkg::ST_ALLOC;
                raddr_next = {page_reg, bba_pkg::OFF_W'({4'd0, hit} << (4 + c3))}
                           + bba_pkg::HEADER_BYTES;
                rcls_next  = creq_reg;
                if (c3 > creq_reg) begin
                    state_next = bba_pkg::S_SPLIT_RD;
                end else begin
                    state_next = bba_pkg::S_FINISH;
                end
            end
            bba_pkg::S_SPLIT_RD: begin
                c_next    = c_reg - (bba_pkg::CLS_W + 1)'(1);
                ram_raddr = {c_next[bba_pkg::CLS_W-1:0], page_reg};
                state_next = bba_pkg::S_SPLIT_WR;
            end
            bba_pkg::S_SPLIT_WR: begin
                // mark the upper half free in the lower class
                row_new = row;
                row_new[bidx | bba_pkg::ROW_IDX_W'(1)] = 1'b1;
                ram_we    = 1'b1;
                ram_wdata = row_new;
                sum_next[c3][page_reg] = 1'b1;
                if (c3 > creq_reg) begin
                    state_next = bba_pkg::S_SPLIT_RD;
                end else begin
                    state_next = bba_pkg::S_FINISH;
                end
            end
            bba_pkg::S_FREE_RD: begin
                ram_raddr  = {c3, page_reg};
                state_next = bba_pkg::S_FREE_WR;
            end
            bba_pkg::S_FREE_WR: begin
                first_next = 1'b0;
                priority if (first_reg && row[bidx]) begin
                    // already free: drop
                    state_next = bba_pkg::S_FINISH;
                end else if (!row[buddy]) begin
                    row_new = row;
                    row_new[bidx] = 1'b1;
                    ram_we    = 1'b1;
                    ram_wdata = row_new;
                    sum_next[c3][page_reg] = 1'b1;
                    state_next = bba_pkg::S_FINISH;
                end else begin
                    // merge with the buddy and climb one class, or release the page at the top
                    row_new = row;
                    row_new[buddy] = 1'b0;
                    ram_we    = 1'b1;
                    ram_wdata = row_new;
                    sum_next[c3][page_reg] = |row_new;
                    off_next = off_reg & ~(bba_pkg::OFF_W'(16) << c3);
                    if (c_reg == bba_pkg::TOP_CLASS) begin
                        taken_next[page_reg] = 1'b0;
                        if (count_reg != '0) begin
                            count_next = count_reg - bba_pkg::COUNT_W'(1);
                        end
                        state_next = bba_pkg::S_FINISH;
                    end else begin
                        c_next = c_reg + (bba_pkg::CLS_W + 1)'(1);
                        state_next = bba_pkg::S_FREE_RD;
                    end
                end
            end
            bba_pkg::S_FINISH: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase

        res.status = status_reg;
        res.addr   = (status_reg == bba_pkg::ST_ALLOC) ? raddr_reg : '0;
        res.cls    = (status_reg == bba_pkg::ST_ALLOC) ? rcls_reg : '0;
        res.pages  = count_reg;
        if (start == '1) begin
            res.pages = count_reg;
        end
    end

endmodule

// ===== hw/rtl/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Binary buddy allocator over 64 pages of 4 KB, classes 16 B to 2 KB.
// ----------------------------------------------------------------------------
// Usage: present an allocate (s_func = 0, s_request_bytes) or a free
// (s_func = 1, s_block_address, s_block_class) on the s_ channel. Each
// transaction yields exactly one result on the m_ channel: status, payload
// address and granted class (allocations only) and the pages held afterward.
// Requests are handled one at a time. An allocation searches the classes
// upward from the smallest that fits, takes an existing free block or claims
// a fresh page, and splits it down one class level at a time; a zero or
// oversized request ends without a search. A free is dropped early (below the
// header, page not held, block already free), else it reads and writes one
// class row per level as it merges. Each level costs a read-modify-write of
// one free-bitmap row on the single row memory. A finished result
// sits in the output register while the next request is already accepted; a
// stalled receiver holds the engine only when that second result is ready too.
// Reset clears the row summary bits, the page bitmap and the page count, so
// the pool starts empty with no clearing pass; the row memory needs no reset.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [11:0]                   s_request_bytes,
    input  logic [17:0]                   s_block_address,
    input  logic [2:0]                    s_block_class,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [17:0]                   m_payload_address,
    output logic [2:0]                    m_granted_class,
    output logic [6:0]                    m_pages_in_use
);

    logic                                  ram_we;
    logic [bba_pkg::RAM_ADDR_W-1:0]        ram_waddr;
    logic [bba_pkg::ROW_W-1:0]             ram_wdata;
    logic [bba_pkg::RAM_ADDR_W-1:0]        ram_raddr;
    logic [bba_pkg::ROW_W-1:0]             ram_rdata;
    logic                                  res_valid;
    logic                                  res_ready;
    bba_pkg::res_t                         res;
    logic                                  m_valid_reg, m_valid_next;
    bba_pkg::res_t                         m_res_reg, m_res_next;

    bba_row_ram #(
        .ADDR_W (bba_pkg::RAM_ADDR_W),
        .DATA_W (bba_pkg::ROW_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req_func  (s_func),
        .req_bytes (s_request_bytes),
        .req_addr  (s_block_address),
        .req_cls   (s_block_class),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // load the output register when it is empty or being drained
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_res_reg <= m_res_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_res_reg.status;
    assign m_payload_address = m_res_reg.addr;
    assign m_granted_class   = m_res_reg.cls;
    assign m_pages_in_use    = m_res_reg.pages;

endmodule

// ===== tb/tb_buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_buddy_block_allocator
// Self-checking bench: drives allocate/free requests with random gaps and
// receiver stalls, predicts each result with a behavioral allocator model
// and compares every returned transaction field by field.
// ----------------------------------------------------------------------------
module tb_buddy_block_allocator;

    localparam int PAGES      = bba_pkg::PAGES;
    localparam int CLASSES    = bba_pkg::CLASSES;
    localparam int POOL_BYTES = PAGES * 4096;
    localparam int MAP_SLOTS  = POOL_BYTES / 16;

    typedef struct packed {
        bba_pkg::status_t status;
        logic [17:0]      addr;
        logic [2:0]       cls;
        logic [6:0]       pages;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_func;
    logic [11:0] s_request_bytes;
    logic [17:0] s_block_address;
    logic [2:0]  s_block_class;
    logic        m_valid;
    logic        m_ready;
    logic [2:0]  m_status;
    logic [17:0] m_payload_address;
    logic [2:0]  m_granted_class;
    logic [6:0]  m_pages_in_use;

    // model state
    bit          blk_free [CLASSES][MAP_SLOTS];
    bit          page_held [PAGES];
    int unsigned held_pages;

    outcome_t    expected_q[$];
    int          mismatches;
    bit          hold_off;
    bit          stall_en;

    // live grants, used to build well-formed frees
    logic [17:0] live_addr[$];
    logic [2:0]  live_cls[$];

    buddy_block_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_func(s_func),
        .s_request_bytes(s_request_bytes), .s_block_address(s_block_address),
        .s_block_class(s_block_class),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_payload_address(m_payload_address), .m_granted_class(m_granted_class),
        .m_pages_in_use(m_pages_in_use)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic int unsigned class_bytes(int unsigned c);
        return 16 << c;
    endfunction

    // predict one allocate
    function automatic outcome_t predict_alloc(int unsigned req);
        outcome_t    r;
        int unsigned need, creq, start, p;
        r = '{status: bba_pkg::ST_ZERO, addr: '0, cls: '0, pages: '0};
        if (req == 0) begin
            r.pages = held_pages[6:0];
            return r;
        end
        need = req + 16;
        creq = CLASSES;
        for (int c = 0; c < CLASSES; c++) begin
            if (class_bytes(c) >= need && creq == CLASSES) creq = c;
        end
        if (creq >= CLASSES) begin
            r.status = bba_pkg::ST_LARGE;
            r.pages  = held_pages[6:0];
            return r;
        end
        for (int c = creq; c < CLASSES; c++) begin
            for (int i = 0; i < POOL_BYTES / class_bytes(c); i++) begin
                if (blk_free[c][i]) begin
                    blk_free[c][i] = 1'b0;
                    start = i * class_bytes(c);
                    for (int k = c; k > creq; k--)
                        blk_free[k-1][(start + class_bytes(k-1)) / class_bytes(k-1)] = 1'b1;
                    r.status = bba_pkg::ST_ALLOC;
                    r.addr   = 18'(start + 16);
                    r.cls    = 3'(creq);
                    r.pages  = held_pages[6:0];
                    return r;
                end
            end
        end
        p = PAGES;
        for (int q = PAGES - 1; q >= 0; q--) begin
            if (!page_held[q]) p = q;
        end
        if (p >= PAGES) begin
            r.status = bba_pkg::ST_OOM;
            r.pages  = held_pages[6:0];
            return r;
        end
        page_held[p] = 1'b1;
        held_pages++;
        start = p * 4096;
        for (int k = CLASSES; k > creq; k--)
            blk_free[k-1][(start + class_bytes(k-1)) / class_bytes(k-1)] = 1'b1;
        r.status = bba_pkg::ST_ALLOC;
        r.addr   = 18'(start + 16);
        r.cls    = 3'(creq);
        r.pages  = held_pages[6:0];
        return r;
    endfunction

    // apply one free; it always reports freed
    function automatic void predict_free(int unsigned addr, int unsigned cls);
        int unsigned b, buddy, pg;
        if (addr < 16) return;
        b = addr - 16;
        if (b >= POOL_BYTES) return;
        b = b - (b % class_bytes(cls));
        pg = b / 4096;
        if (!page_held[pg]) return;
        if (blk_free[cls][b / class_bytes(cls)]) return;
        for (int c = cls; c < CLASSES; c++) begin
            buddy = b ^ class_bytes(c);
            if (!blk_free[c][buddy / class_bytes(c)]) begin
                blk_free[c][b / class_bytes(c)] = 1'b1;
                return;
            end
            blk_free[c][buddy / class_bytes(c)] = 1'b0;
            if (buddy < b) b = buddy;
            if (c == CLASSES - 1) begin
                page_held[pg] = 1'b0;
                if (held_pages > 0) held_pages--;
                return;
            end
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one transaction and queue its predicted outcome
    task automatic send_request(input logic func, input logic [11:0] req,
                                input logic [17:0] addr, input logic [2:0] cls);
        outcome_t    r;
        int unsigned gap;
        gap = stall_en ? pick_gap() : 0;
        // drop valid only across an idle gap
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_func          <= func;
        s_request_bytes <= req;
        s_block_address <= addr;
        s_block_class   <= cls;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (func == 1'b0) begin
            r = predict_alloc(req);
            if (r.status == bba_pkg::ST_ALLOC) begin
                live_addr.push_back(r.addr);
                live_cls.push_back(r.cls);
            end
        end else begin
            predict_free(addr, cls);
            r = '{status: bba_pkg::ST_FREED, addr: '0, cls: '0, pages: held_pages[6:0]};
        end
        expected_q.push_back(r);
    endtask

    task automatic free_live(input int idx);
        logic [17:0] a;
        logic [2:0]  c;
        a = live_addr[idx];
        c = live_cls[idx];
        live_addr.delete(idx);
        live_cls.delete(idx);
        send_request(1'b1, 12'($urandom), a, c);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic test_directed();
        send_request(1'b0, 12'd0, 18'h3FFFF, 3'd7);      // zero request
        send_request(1'b0, 12'd4095, 18'd0, 3'd0);       // too large
        send_request(1'b0, 12'd2033, 18'd0, 3'd0);       // just over top class
        send_request(1'b0, 12'd2032, 18'd0, 3'd0);       // fills top class
        send_request(1'b0, 12'd1, 18'd0, 3'd0);          // smallest class
        send_request(1'b0, 12'd17, 18'd0, 3'd0);
        send_request(1'b1, 12'd0, 18'd5, 3'd0);          // below header
        send_request(1'b1, 12'd0, 18'h3FFFF, 3'd0);      // page not held
        send_request(1'b1, 12'd0, 18'd20, 3'd0);         // misaligned free
        send_request(1'b1, 12'd0, 18'd16, 3'd0);         // double free
        free_live(0);
        while (live_addr.size() != 0) free_live(0);
        send_request(1'b1, 12'hFFF, 18'd4112, 3'd7);     // free into page not held
        drain();
    endtask

    // fill the whole pool with top-class grants to reach out of memory
    task automatic test_out_of_memory();
        for (int i = 0; i < 2 * PAGES + 2; i++)
            send_request(1'b0, 12'($urandom_range(1009, 2032)), 18'd0, 3'd0);
        while (live_addr.size() != 0) free_live($urandom_range(0, live_addr.size() - 1));
        drain();
    endtask

    task automatic test_random();
        int unsigned roll;
        for (int n = 0; n < 100; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                send_request(1'b0, 12'($urandom_range(1, 300) >> $urandom_range(0, 4)),
                             18'($urandom), 3'($urandom));
            end else if (roll < 55) begin
                send_request(1'b0, 12'($urandom), 18'($urandom), 3'($urandom));
            end else if (roll < 88 && live_addr.size() != 0) begin
                free_live($urandom_range(0, live_addr.size() - 1));
            end else begin
                send_request(1'b1, 12'($urandom), 18'($urandom), 3'($urandom));
            end
        end
        while (live_addr.size() != 0) free_live(0);
        drain();
    endtask

    // long receiver hold-off while requests keep coming
    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 12; i++)
            send_request(1'b0, 12'($urandom_range(1, 100)), 18'd0, 3'd0);
        while (live_addr.size() != 0) free_live(0);
        drain();
    endtask

    // receiver ready generation
    initial begin
        int unsigned cnt;
        int unsigned gap;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                cnt = 0;
                while (cnt < 300) begin
                    @(posedge aclk);
                    cnt++;
                end
                hold_off = 1'b0;
            end else if (stall_en && $urandom_range(0, 99) < 30) begin
                gap = pick_gap();
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        outcome_t want;
        outcome_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{status: bba_pkg::status_t'(m_status), addr: m_payload_address,
                    cls: m_granted_class, pages: m_pages_in_use};
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = expected_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        mismatches      = 0;
        hold_off        = 1'b0;
        stall_en        = 1'b0;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_func          = 1'b0;
        s_request_bytes = '0;
        s_block_address = '0;
        s_block_class   = '0;
        held_pages      = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        stall_en = 1'b1;
        test_out_of_memory();
        test_random();
        test_backpressure();
        if (expected_q.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
